// File: hdl/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion helpers. They expand to nothing in synthesis.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
// Implication checked on every clock edge outside of reset.
`define ASSERT_RST(label, clk, rst_n, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
// Condition in one cycle requires a consequence in the next cycle.
`define ASSERT_RST_NEXT(label, clk, rst_n, pre, post, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
    else $error(msg);
`else
`define ASSERT_RST(label, clk, rst_n, prop, msg)
`define ASSERT_RST_NEXT(label, clk, rst_n, pre, post, msg)
`endif
`endif

// File: hdl/mexp_pkg.sv
// ----------------------------------------------------------------------------
// mexp_pkg
// Shared widths, the fixed prime and the multiplier status type.
// ----------------------------------------------------------------------------
package mexp_pkg;

  localparam int unsigned MEXP_W     = 64;
  localparam int unsigned MEXP_CNT_W = $clog2(MEXP_W);

  // The prime 2^64 - 59.
  localparam logic [MEXP_W-1:0] MEXP_PRIME = 64'hFFFF_FFFF_FFFF_FFC5;

  typedef struct packed {
    logic busy;
    logic done;
  } mexp_mm_status_t;

endpackage

// File: hdl/modular_exponentiation_64_unit.sv
// ----------------------------------------------------------------------------
// modular_exponentiation_64_unit: base^exponent mod 2^64-59, square-and-multiply
// An item needs 64+popcount(exponent) products in one shared multiplier.
// The unit works on one item at a time and takes no new word until the last is finished.
// Reset clears the sequencer and the output valid; no clearing pass is needed.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module modular_exponentiation_64_unit (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        in_valid_i,
  output logic                        in_stall_o,
  input  logic [mexp_pkg::MEXP_W-1:0] base_i,
  input  logic [mexp_pkg::MEXP_W-1:0] exponent_i,
  output logic                        out_valid_o,
  input  logic                        out_stall_i,
  output logic [mexp_pkg::MEXP_W-1:0] power_mod_prime_o
);
  import mexp_pkg::*;

  // Sequencer states. The exponent is scanned from its top bit down; every
  // bit costs one squaring, and a set bit costs one more product by the base.
  localparam logic [2:0] S_IDLE     = 3'd0;
  localparam logic [2:0] S_SQ       = 3'd1;
  localparam logic [2:0] S_SQ_WAIT  = 3'd2;
  localparam logic [2:0] S_MUL      = 3'd3;
  localparam logic [2:0] S_MUL_WAIT = 3'd4;
  localparam logic [2:0] S_DONE     = 3'd5;

  localparam logic [MEXP_CNT_W-1:0] LastBit = MEXP_CNT_W'(MEXP_W - 1);
  localparam logic [MEXP_W-1:0]     One     = MEXP_W'(1);

  logic [2:0]            state_q, state_d;
  logic [MEXP_W-1:0]     base_q, base_d;
  logic [MEXP_W-1:0]     exp_q, exp_d;
  logic [MEXP_W-1:0]     r_q, r_d;
  logic [MEXP_CNT_W-1:0] bit_q, bit_d;
  logic [MEXP_W-1:0]     res_q, res_d;
  logic                  out_valid_q, out_valid_d;

  logic                  accept;
  logic [MEXP_W-1:0]     base_red;
  logic                  mm_start;
  logic [MEXP_W-1:0]     mm_b;
  logic [MEXP_W-1:0]     mm_product;
  mexp_mm_status_t       mm_status;

  // The block takes a new word only when the sequencer is idle.
  assign in_stall_o = (state_q != S_IDLE);
  assign accept     = in_valid_i && !in_stall_o;

  // Twice the prime exceeds 2^64, so one subtraction puts any base in range.
  assign base_red = (base_i >= MEXP_PRIME) ? (base_i - MEXP_PRIME) : base_i;

  // The multiplier is launched for one cycle from a start state. The running
  // result is always the first operand; the second is itself when squaring
  // and the reduced base when multiplying.
  assign mm_start = (state_q == S_SQ) || (state_q == S_MUL);
  assign mm_b     = (state_q == S_SQ) ? r_q : base_q;

  mexp_modmul u_modmul (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .start_i   (mm_start),
    .a_i       (r_q),
    .b_i       (mm_b),
    .product_o (mm_product),
    .status_o  (mm_status)
  );

  always_comb begin
    state_d     = state_q;
    base_d      = base_q;
    exp_d       = exp_q;
    r_d         = r_q;
    bit_d       = bit_q;
    res_d       = res_q;
    out_valid_d = out_valid_q;

    // A waiting result leaves as soon as the consumer takes it.
    if (out_valid_q && !out_stall_i) begin
      out_valid_d = 1'b0;
    end

    unique case (state_q)
      S_IDLE: begin
        if (accept) begin
          base_d  = base_red;
          exp_d   = exponent_i;
          r_d     = One;
          bit_d   = '0;
          state_d = S_SQ;
        end
      end
      S_SQ: begin
        state_d = S_SQ_WAIT;
      end
      S_SQ_WAIT: begin
        if (mm_status.done) begin
          r_d = mm_product;
          if (exp_q[MEXP_W-1]) begin
            state_d = S_MUL;
          end else if (bit_q == LastBit) begin
            state_d = S_DONE;
          end else begin
            bit_d   = bit_q + 1'b1;
            exp_d   = {exp_q[MEXP_W-2:0], 1'b0};
            state_d = S_SQ;
          end
        end
      end
      S_MUL: begin
        state_d = S_MUL_WAIT;
      end
      S_MUL_WAIT: begin
        if (mm_status.done) begin
          r_d = mm_product;
          if (bit_q == LastBit) begin
            state_d = S_DONE;
          end else begin
            bit_d   = bit_q + 1'b1;
            exp_d   = {exp_q[MEXP_W-2:0], 1'b0};
            state_d = S_SQ;
          end
        end
      end
      S_DONE: begin
        // Hold the finished power until the output register is free.
        if (!out_valid_q || !out_stall_i) begin
          res_d       = r_q;
          out_valid_d = 1'b1;
          state_d     = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      bit_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      bit_q       <= bit_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    base_q <= base_d;
    exp_q  <= exp_d;
    r_q    <= r_d;
    res_q  <= res_d;
  end

  assign out_valid_o       = out_valid_q;
  assign power_mod_prime_o = res_q;

  // The multiplier must never be relaunched while it is still working.
  `ASSERT_RST(a_start_idle_mm, clk_i, rst_ni, mm_start |-> !mm_status.busy,
              "modmul restarted while busy")
  // A finished product is only expected while the sequencer waits for it.
  `ASSERT_RST(a_done_in_wait, clk_i, rst_ni,
              mm_status.done |-> (state_q == S_SQ_WAIT || state_q == S_MUL_WAIT),
              "unexpected modmul done")
  // The running result stays reduced below the prime during a computation.
  `ASSERT_RST(a_r_reduced, clk_i, rst_ni, (state_q != S_IDLE) |-> (r_q < MEXP_PRIME),
              "running result not reduced")
  // Leaving the final state always presents a result.
  `ASSERT_RST_NEXT(a_done_presents, clk_i, rst_ni,
                   (state_q == S_DONE) && (state_d == S_IDLE),
                   out_valid_o && (power_mod_prime_o < MEXP_PRIME),
                   "result missing or out of range")

endmodule

// File: hdl/mexp_modmul.sv
// ----------------------------------------------------------------------------
// mexp_modmul
// Bit-serial modular multiplier: one multiplier bit per cycle.
// ----------------------------------------------------------------------------
module mexp_modmul (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              start_i,
  input  logic [mexp_pkg::MEXP_W-1:0]       a_i,
  input  logic [mexp_pkg::MEXP_W-1:0]       b_i,
  output logic [mexp_pkg::MEXP_W-1:0]       product_o,
  output mexp_pkg::mexp_mm_status_t         status_o
);
  import mexp_pkg::*;

  localparam logic [MEXP_W:0]       PrimeX  = {1'b0, MEXP_PRIME};
  localparam logic [MEXP_CNT_W-1:0] LastCnt = MEXP_CNT_W'(MEXP_W - 1);

  logic [MEXP_W-1:0]     a_q, a_d;
  logic [MEXP_W-1:0]     b_q, b_d;
  logic [MEXP_W-1:0]     acc_q, acc_d;
  logic [MEXP_CNT_W-1:0] cnt_q, cnt_d;
  logic                  busy_q, busy_d;
  logic                  done_q, done_d;

  logic [MEXP_W:0]   sum, sum_red, dbl, dbl_red;
  logic [MEXP_W-1:0] acc_add, a_dbl;

  // Both operands stay below the prime, so one conditional subtraction
  // brings the sum and the doubled value back into range.
  always_comb begin
    sum     = {1'b0, acc_q} + {1'b0, a_q};
    sum_red = sum - PrimeX;
    acc_add = (sum >= PrimeX) ? sum_red[MEXP_W-1:0] : sum[MEXP_W-1:0];
    dbl     = {a_q, 1'b0};
    dbl_red = dbl - PrimeX;
    a_dbl   = (dbl >= PrimeX) ? dbl_red[MEXP_W-1:0] : dbl[MEXP_W-1:0];
  end

  always_comb begin
    a_d    = a_q;
    b_d    = b_q;
    acc_d  = acc_q;
    cnt_d  = cnt_q;
    busy_d = busy_q;
    done_d = 1'b0;
    if (start_i) begin
      a_d    = a_i;
      b_d    = b_i;
      acc_d  = '0;
      cnt_d  = '0;
      busy_d = 1'b1;
    end else if (busy_q) begin
      if (b_q[0]) begin
        acc_d = acc_add;
      end
      a_d   = a_dbl;
      b_d   = {1'b0, b_q[MEXP_W-1:1]};
      cnt_d = cnt_q + 1'b1;
      if (cnt_q == LastCnt) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q  <= '0;
      busy_q <= 1'b0;
      done_q <= 1'b0;
    end else begin
      cnt_q  <= cnt_d;
      busy_q <= busy_d;
      done_q <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    a_q   <= a_d;
    b_q   <= b_d;
    acc_q <= acc_d;
  end

  assign product_o     = acc_q;
  assign status_o.busy = busy_q;
  assign status_o.done = done_q;

endmodule

// File: test/tb.sv
// ----------------------------------------------------------------------------
// Testbench for modular_exponentiation_64_unit
// Drives base/exponent words through the valid/stall input channel and checks
// every power_mod_prime word against a typed-in result or a bit-accurate
// square-and-multiply predictor. A directed table comes first, then randomized words. Both
// channels idle at random, and the receiver holds off once long enough to
// back the unit up into its input.
// ----------------------------------------------------------------------------
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  import mexp_pkg::*;

  // Number of random words after the directed table.
  localparam int unsigned RANDOM_WORDS   = 78;
  // Percent chance that a side idles in a given cycle.
  localparam int unsigned IDLE_PCT       = 28;
  // The receiver holds off once, after this many results, for this many cycles.
  // The hold-off is long enough that the unit must stall its input while the
  // sender keeps offering.
  localparam int unsigned HOLDOFF_AT     = 30;
  localparam int unsigned HOLDOFF_CYCLES = 20000;
  // Results in this range are taken with no receiver stall at all.
  localparam int unsigned QUIET_RES_LO   = 60;
  localparam int unsigned QUIET_RES_HI   = 85;
  // Random words in this range are offered with no sender gap at all.
  localparam int unsigned QUIET_SEND_LO  = 50;
  localparam int unsigned QUIET_SEND_HI  = 70;
  // The longest gap with no handshake is the slowest item plus the hold-off,
  // so this limit leaves a wide margin.
  localparam int unsigned STUCK_LIMIT    = 150000;
  // Cycles to watch for stray results once everything has arrived.
  localparam int unsigned DRAIN_CYCLES   = 9000;

  typedef struct packed {
    logic [MEXP_W-1:0] base;
    logic [MEXP_W-1:0] exponent;
    logic              known;   // result column below is valid
    logic [MEXP_W-1:0] result;
  } stim_row_t;

  typedef struct packed {
    logic [MEXP_W-1:0] base;
    logic [MEXP_W-1:0] exponent;
    logic [MEXP_W-1:0] power;
  } power_rec_t;

  localparam logic [MEXP_W-1:0] ALL_ONES = '1;

  // Directed words. Rows with a typed-in result are read straight off the
  // definition; the rest go through the predictor.
  localparam int unsigned DIRECTED_COUNT = 22;
  localparam stim_row_t DIRECTED_ROWS [DIRECTED_COUNT] = '{
    // Zero exponent gives one, even for a zero base or a base equal to the prime.
    '{64'h0, 64'h0, 1'b1, 64'h1},
    '{MEXP_PRIME, 64'h0, 1'b1, 64'h1},
    '{ALL_ONES, 64'h0, 1'b1, 64'h1},
    // A base equal to the prime reduces to zero.
    '{MEXP_PRIME, 64'h1, 1'b1, 64'h0},
    '{MEXP_PRIME, ALL_ONES, 1'b1, 64'h0},
    '{64'h0, 64'h1, 1'b1, 64'h0},
    '{64'h0, ALL_ONES, 1'b1, 64'h0},
    '{64'h1, ALL_ONES, 1'b1, 64'h1},
    // Bases above the prime are reduced by one subtraction.
    '{MEXP_PRIME + 64'h1, ALL_ONES, 1'b1, 64'h1},
    '{ALL_ONES, 64'h1, 1'b1, 64'h3A},
    '{MEXP_PRIME - 64'h1, 64'h2, 1'b1, 64'h1},
    '{MEXP_PRIME - 64'h1, 64'h1, 1'b1, MEXP_PRIME - 64'h1},
    '{64'h7, 64'h1, 1'b1, 64'h7},
    '{64'h2, 64'd63, 1'b1, 64'h8000_0000_0000_0000},
    '{64'h2, 64'd64, 1'b1, 64'h3B},
    // Fermat: a^(p-1) is one for any base not divisible by p.
    '{64'h3, MEXP_PRIME - 64'h1, 1'b1, 64'h1},
    '{ALL_ONES, ALL_ONES, 1'b0, 64'h0},
    '{64'h8000_0000_0000_0000, 64'h8000_0000_0000_0000, 1'b0, 64'h0},
    '{64'h0123_4567_89AB_CDEF, 64'hFEDC_BA98_7654_3210, 1'b0, 64'h0},
    '{MEXP_PRIME - 64'h2, 64'h5555_5555_5555_5555, 1'b0, 64'h0},
    '{64'hAAAA_AAAA_AAAA_AAAA, 64'hAAAA_AAAA_AAAA_AAAA, 1'b0, 64'h0},
    '{64'h5555_5555_5555_5555, 64'h5555_5555_5555_5555, 1'b0, 64'h0}
  };

  logic              clk_i             = 1'b0;
  logic              rst_ni            = 1'b0;
  logic              in_valid_i        = 1'b0;
  logic              in_stall_o;
  logic [MEXP_W-1:0] base_i            = '0;
  logic [MEXP_W-1:0] exponent_i        = '0;
  logic              out_valid_o;
  logic              out_stall_i       = 1'b0;
  logic [MEXP_W-1:0] power_mod_prime_o;

  modular_exponentiation_64_unit dut (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .in_valid_i       (in_valid_i),
    .in_stall_o       (in_stall_o),
    .base_i           (base_i),
    .exponent_i       (exponent_i),
    .out_valid_o      (out_valid_o),
    .out_stall_i      (out_stall_i),
    .power_mod_prime_o(power_mod_prime_o)
  );

  // 20 ns clock period.
  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  // Powers still owed by the unit, oldest first.
  power_rec_t  expected_powers[$];
  power_rec_t  oldest_power;
  int unsigned words_sent      = 0;
  int unsigned results_checked = 0;
  int unsigned mismatches      = 0;
  int unsigned holdoff_left    = 0;
  bit          holdoff_done    = 1'b0;

  // a * b mod p with a already below p. Built by doubling a and adding it in
  // for each set bit of b, so nothing ever exceeds 64 bits.
  function automatic logic [MEXP_W-1:0] mul_mod_prime(input logic [MEXP_W-1:0] a,
                                                      input logic [MEXP_W-1:0] b);
    logic [MEXP_W-1:0] acc;
    logic [MEXP_W-1:0] room;
    acc = '0;
    for (int i = 0; i < MEXP_W; i++) begin
      if (b[i]) begin
        room = MEXP_PRIME - a;
        if (acc >= room) acc = acc - room;
        else acc = acc + a;
      end
      if (a >= MEXP_PRIME - a) a = a + a - MEXP_PRIME;
      else a = a + a;
    end
    return acc;
  endfunction

  // base^exponent mod p by left-to-right square-and-multiply. The loop always
  // runs all 64 bits, so a zero exponent naturally leaves the result at one.
  function automatic logic [MEXP_W-1:0] pow_mod_prime(input logic [MEXP_W-1:0] base,
                                                      input logic [MEXP_W-1:0] exponent);
    logic [MEXP_W-1:0] b;
    logic [MEXP_W-1:0] r;
    b = base;
    if (b >= MEXP_PRIME) b = b - MEXP_PRIME;
    r = 64'h1;
    for (int i = MEXP_W - 1; i >= 0; i--) begin
      r = mul_mod_prime(r, r);
      if (exponent[i]) r = mul_mod_prime(r, b);
    end
    return r;
  endfunction

  // Offers one word and returns in the time step of the edge that accepted
  // it. With may_idle set, random gaps are put in front of the word. Each
  // time step sees only one assignment to in_valid_i.
  task automatic send_word(input logic [MEXP_W-1:0] b, input logic [MEXP_W-1:0] e,
                           input logic known, input logic [MEXP_W-1:0] result,
                           input bit may_idle);
    power_rec_t rec;
    if (may_idle) begin
      while ($urandom_range(99) < IDLE_PCT) begin
        in_valid_i <= 1'b0;
        @(posedge clk_i);
      end
    end
    in_valid_i <= 1'b1;
    base_i     <= b;
    exponent_i <= e;
    // Values read at the edge are the ones from before it, so this sees the
    // stall that the unit presented in the cycle that just ended.
    do @(posedge clk_i); while (in_stall_o);
    rec.base     = b;
    rec.exponent = e;
    rec.power    = known ? result : pow_mod_prime(b, e);
    expected_powers.push_back(rec);
    words_sent++;
  endtask

  // Result side: checks each accepted word against the oldest expectation,
  // then decides the stall for the coming cycle. Both live in one process so
  // the hold-off trigger sees the result count without a race.
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (expected_powers.size() == 0) begin
        mismatches++;
        $display("%0t: result word %h arrived with nothing expected", $realtime,
                 power_mod_prime_o);
      end else begin
        oldest_power = expected_powers.pop_front();
        if (power_mod_prime_o !== oldest_power.power) begin
          mismatches++;
          $display("%0t: base %h exponent %h: expected %h, actual %h", $realtime,
                   oldest_power.base, oldest_power.exponent, oldest_power.power,
                   power_mod_prime_o);
        end
        results_checked++;
      end
    end

    if (!holdoff_done && results_checked >= HOLDOFF_AT) begin
      holdoff_done = 1'b1;
      holdoff_left = HOLDOFF_CYCLES;
    end
    if (holdoff_left > 0) begin
      holdoff_left--;
      out_stall_i <= 1'b1;
    end else if (results_checked >= QUIET_RES_LO && results_checked < QUIET_RES_HI) begin
      out_stall_i <= 1'b0;
    end else begin
      out_stall_i <= ($urandom_range(99) < IDLE_PCT);
    end
  end

  // Watchdog: ends the run when neither channel has moved a word for too long.
  initial begin : watchdog
    int unsigned stuck;
    stuck = 0;
    wait (rst_ni);
    while (stuck < STUCK_LIMIT) begin
      @(posedge clk_i);
      if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) stuck = 0;
      else stuck++;
    end
    $display("%0t: no handshake for %0d cycles", $realtime, STUCK_LIMIT);
    $display("FAIL");
    $finish;
  end

  initial begin : stimulus
    logic [MEXP_W-1:0] b;
    logic [MEXP_W-1:0] e;
    int unsigned       pick;

    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed table.
    for (int unsigned i = 0; i < DIRECTED_COUNT; i++) begin
      send_word(DIRECTED_ROWS[i].base, DIRECTED_ROWS[i].exponent,
                DIRECTED_ROWS[i].known, DIRECTED_ROWS[i].result, 1'b1);
    end

    // Random words. Most are full-width random values; the rest aim at the
    // edges of the base range and at short, sparse and dense exponents.
    for (int unsigned i = 0; i < RANDOM_WORDS; i++) begin
      pick = $urandom_range(9);
      case (pick)
        6: b = MEXP_PRIME + 64'($urandom_range(58));
        7: b = 64'($urandom_range(15));
        8: b = MEXP_PRIME - 64'h1 - 64'($urandom_range(15));
        9: b = 64'($urandom_range(1));
        default: b = {$urandom, $urandom};
      endcase
      pick = $urandom_range(9);
      case (pick)
        7: e = 64'($urandom_range(16));
        8: e = 64'h1 << $urandom_range(63);
        9: e = ALL_ONES ^ (64'h1 << $urandom_range(63));
        default: e = {$urandom, $urandom};
      endcase
      send_word(b, e, 1'b0, '0, !(i >= QUIET_SEND_LO && i < QUIET_SEND_HI));
    end
    in_valid_i <= 1'b0;

    // Wait for every owed result, then watch for stray ones.
    while (expected_powers.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);

    $display("Sent %0d words (%0d directed, %0d random), checked %0d results.",
             words_sent, DIRECTED_COUNT, RANDOM_WORDS, results_checked);
    $display("Covered base and exponent extremes, one long receiver hold-off, %0d mismatches.",
             mismatches);
    if (mismatches == 0 && expected_powers.size() == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
